// ===== hw/rtl/svpwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and helpers of the space-vector PWM duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	localparam int AccW  = 36;
	localparam int DutyW = 15;
	localparam int PerW  = 16;
	localparam int VoltW = 16;

	localparam logic signed [VoltW-1:0] SQRT3_HALF_Q15 = 16'sd28378;
	localparam logic signed [AccW-1:0]  HALF_Q31       = 36'sd1073741824;
	localparam logic signed [AccW-1:0]  ROUND_Q16      = 36'sd32768;
	localparam logic signed [AccW-1:0]  DUTY_MAX       = 36'sd32767;

	typedef enum logic [2:0] {
		SEC_ZERO = 3'd0,
		SEC_C1   = 3'd1,
		SEC_C2   = 3'd2,
		SEC_C3   = 3'd3,
		SEC_C4   = 3'd4,
		SEC_C5   = 3'd5,
		SEC_C6   = 3'd6,
		SEC_FULL = 3'd7
	} sec_code_t;

	typedef struct packed {
		logic [DutyW-1:0] duty_a;
		logic [DutyW-1:0] duty_b;
		logic [DutyW-1:0] duty_c;
		logic [2:0]       sector;
		logic             flag_load;
		logic [2:0]       flags;
	} svpwm_res_t;

	function automatic logic [2:0] sector_remap(input sec_code_t code);
		logic [2:0] s;
		unique case (code)
			SEC_C1:  s = 3'd2;
			SEC_C2:  s = 3'd6;
			SEC_C3:  s = 3'd1;
			SEC_C4:  s = 3'd4;
			SEC_C5:  s = 3'd3;
			SEC_C6:  s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] flag_remap(input sec_code_t code);
		logic [2:0] f;
		unique case (code)
			SEC_C1:  f = 3'b110;
			SEC_C2:  f = 3'b011;
			SEC_C3:  f = 3'b010;
			SEC_C4:  f = 3'b101;
			SEC_C5:  f = 3'b100;
			SEC_C6:  f = 3'b001;
			default: f = 3'b000;
		endcase
		return f;
	endfunction

	// Q31 to Q15, round half up, clamp to 0..32767
	function automatic logic [DutyW-1:0] to_duty(input logic signed [AccW-1:0] x);
		logic signed [AccW-1:0] r;
		logic [DutyW-1:0]       d;
		r = (x + ROUND_Q16) >>> 16;
		if (x < 0) begin
			d = '0;
		end else if (r > DUTY_MAX) begin
			d = {DutyW{1'b1}};
		end else begin
			d = r[DutyW-1:0];
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/svpwm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_core
// Sector detection and duty computation for one alpha/beta sample.
// ----------------------------------------------------------------------------
module svpwm_core
	import svpwm_pkg::*;
(
	input  wire logic signed [VoltW-1:0] alpha,
	input  wire logic signed [VoltW-1:0] beta,
	output svpwm_res_t                   res
);

	logic signed [31:0]     prod;
	logic signed [AccW-1:0] ka, bh, xv, yv, zv, t1, t2, d0, d1, d2, da, db, dc;
	logic [2:0]             code_bits;
	sec_code_t              code;

	assign prod = alpha * SQRT3_HALF_Q15;
	assign ka   = AccW'(prod);
	assign bh   = AccW'(beta) <<< 14;
	assign xv   = AccW'(beta) <<< 15;
	assign yv   = bh + ka;
	assign zv   = bh - ka;

	assign code_bits[0] = xv > 0;
	assign code_bits[1] = (ka - bh) > 0;
	assign code_bits[2] = (-bh - ka) > 0;
	assign code         = sec_code_t'(code_bits);

	always_comb begin
		case (code)
			SEC_C1:  begin t1 = zv;  t2 = yv;  end
			SEC_C2:  begin t1 = yv;  t2 = -xv; end
			SEC_C3:  begin t1 = -zv; t2 = xv;  end
			SEC_C4:  begin t1 = -xv; t2 = zv;  end
			SEC_C5:  begin t1 = xv;  t2 = -yv; end
			SEC_C6:  begin t1 = -yv; t2 = -zv; end
			default: begin t1 = '0;  t2 = '0;  end
		endcase
	end

	assign d0 = HALF_Q31 - t1 - t2;
	assign d1 = d0 + (t1 <<< 1);
	assign d2 = d1 + (t2 <<< 1);

	always_comb begin
		case (code)
			SEC_C1:  begin db = d0; da = d1; dc = d2; end
			SEC_C2:  begin da = d0; dc = d1; db = d2; end
			SEC_C3:  begin da = d0; db = d1; dc = d2; end
			SEC_C4:  begin dc = d0; db = d1; da = d2; end
			SEC_C5:  begin db = d0; dc = d1; da = d2; end
			SEC_C6:  begin dc = d0; da = d1; db = d2; end
			default: begin da = d0; db = d0; dc = d0; end
		endcase
	end

	always_comb begin
		res.duty_a    = to_duty(da);
		res.duty_b    = to_duty(db);
		res.duty_c    = to_duty(dc);
		res.sector    = sector_remap(code);
		res.flag_load = (code != SEC_ZERO) && (code != SEC_FULL);
		res.flags     = flag_remap(code);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/space_vector_pwm_duty_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_generator
// Space-vector PWM duties, sector number and phase offsets from alpha/beta.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid/in_ready  | alpha_voltage, beta_voltage
//  output  | out_valid/out_ready| duty_a/b/c, sector_number, offset_first/second/third
//  config  | cfg_valid/cfg_ready| phase_period
//
//  One sample per cycle while out_ready holds; input register, then result register.
//  The sector and duty math is combinational between the two registers.
//  Reset clears both stage valids, the offset flags and the period.
//  A stalled output holds its result; the input stage still fills behind it.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_generator
	import svpwm_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [VoltW-1:0] alpha_voltage,
	input  wire logic signed [VoltW-1:0] beta_voltage,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [DutyW-1:0]             duty_a,
	output logic [DutyW-1:0]             duty_b,
	output logic [DutyW-1:0]             duty_c,
	output logic [2:0]                   sector_number,
	output logic [PerW-1:0]              offset_first,
	output logic [PerW-1:0]              offset_second,
	output logic [PerW-1:0]              offset_third,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [PerW-1:0]         phase_period
);

	logic                    valid_s1, valid_s2;
	logic                    ready_s1, ready_s2;
	logic signed [VoltW-1:0] alpha_s1, beta_s1;
	svpwm_res_t              res;
	logic [DutyW-1:0]        duty_a_s2, duty_b_s2, duty_c_s2;
	logic [2:0]              sector_s2, flags_s2, flags_q;
	logic [PerW-1:0]         period_q;

	svpwm_core u_core (
		.alpha (alpha_s1),
		.beta  (beta_s1),
		.res   (res)
	);

	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
			period_q <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && ready_s2 && res.flag_load) begin
				flags_q <= res.flags;
			end
			if (cfg_valid && cfg_ready) begin
				period_q <= phase_period;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			alpha_s1 <= alpha_voltage;
			beta_s1  <= beta_voltage;
		end
		if (valid_s1 && ready_s2) begin
			duty_a_s2 <= res.duty_a;
			duty_b_s2 <= res.duty_b;
			duty_c_s2 <= res.duty_c;
			sector_s2 <= res.sector;
			flags_s2  <= res.flag_load ? res.flags : flags_q;
		end
	end

	assign out_valid     = valid_s2;
	assign duty_a        = duty_a_s2;
	assign duty_b        = duty_b_s2;
	assign duty_c        = duty_c_s2;
	assign sector_number = sector_s2;
	assign offset_first  = flags_s2[0] ? period_q : '0;
	assign offset_second = flags_s2[1] ? period_q : '0;
	assign offset_third  = flags_s2[2] ? period_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/svpwm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_checker
// Port-level checks of the space-vector PWM duty generator.
// ----------------------------------------------------------------------------
module svpwm_checker
	import svpwm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [DutyW-1:0] duty_a,
	input wire logic [DutyW-1:0] duty_b,
	input wire logic [DutyW-1:0] duty_c,
	input wire logic [2:0]       sector_number,
	input wire logic [PerW-1:0]  offset_first,
	input wire logic [PerW-1:0]  offset_second,
	input wire logic [PerW-1:0]  offset_third
);

	// hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
			&& $stable(duty_c) && $stable(sector_number))
		else $error("output transaction changed while stalled");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sector_number == 3'd0 |->
			duty_a == 15'd16384 && duty_b == 15'd16384 && duty_c == 15'd16384)
		else $error("zero vector without half duties");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sector_number != 3'd7)
		else $error("sector number out of range");

	a_offsets_agree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (offset_first == '0 || offset_second == '0
			|| offset_first == offset_second)
			&& (offset_first == '0 || offset_third == '0 || offset_first == offset_third)
			&& (offset_second == '0 || offset_third == '0
			|| offset_second == offset_third))
		else $error("nonzero phase offsets disagree");

endmodule

bind space_vector_pwm_duty_generator svpwm_checker u_svpwm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.duty_a        (duty_a),
	.duty_b        (duty_b),
	.duty_c        (duty_c),
	.sector_number (sector_number),
	.offset_first  (offset_first),
	.offset_second (offset_second),
	.offset_third  (offset_third)
);
`default_nettype wire

// ===== verif/svpwm_duty_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_duty_checker
// Watches the sample, result and period channels of the space-vector PWM duty
// generator. Predicts duties, sector number and phase offsets per accepted
// sample, queues them in order and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module svpwm_duty_checker
	import svpwm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [VoltW-1:0] alpha_voltage,
	input  logic signed [VoltW-1:0] beta_voltage,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [DutyW-1:0]        duty_a,
	input  logic [DutyW-1:0]        duty_b,
	input  logic [DutyW-1:0]        duty_c,
	input  logic [2:0]              sector_number,
	input  logic [PerW-1:0]         offset_first,
	input  logic [PerW-1:0]         offset_second,
	input  logic [PerW-1:0]         offset_third,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [PerW-1:0]         phase_period,
	output int                      fail_count,
	output int                      pending
);

	typedef struct {
		logic signed [VoltW-1:0] alpha;
		logic signed [VoltW-1:0] beta;
		logic [DutyW-1:0]        duty_a;
		logic [DutyW-1:0]        duty_b;
		logic [DutyW-1:0]        duty_c;
		logic [2:0]              sector;
		logic [PerW-1:0]         off_first;
		logic [PerW-1:0]         off_second;
		logic [PerW-1:0]         off_third;
	} duty_expect_t;

	logic [PerW-1:0] period_now;
	logic [2:0]      shift_flags;
	duty_expect_t    duty_q[$];
	int              mismatches;

	assign fail_count = mismatches;

	function automatic logic [DutyW-1:0] q31_to_q15(input longint x);
		longint r;
		if (x < 0)
			return '0;
		r = (x + 64'sd32768) >>> 16;
		if (r > 32767)
			return {DutyW{1'b1}};
		return r[DutyW-1:0];
	endfunction

	// Advances the shift flags as a side effect.
	function automatic duty_expect_t predict_duties(input logic signed [VoltW-1:0] alpha,
			input logic signed [VoltW-1:0] beta);
		longint     al, be, ka, bh, bx, y, z, t1, t2, d0, d1, d2, da, db, dc, half;
		logic [2:0] bits;
		sec_code_t  code;
		duty_expect_t e;
		al = alpha;
		be = beta;
		half = longint'(HALF_Q31);
		ka = al * longint'(SQRT3_HALF_Q15);
		bh = be * 16384;
		bx = be * 32768;
		y = bh + ka;
		z = bh - ka;
		bits = {(-bh - ka) > 0, (-bh + ka) > 0, bx > 0};
		code = sec_code_t'(bits);
		t1 = 0;
		t2 = 0;
		case (code)
			SEC_C1: begin t1 = z;   t2 = y;   end
			SEC_C2: begin t1 = y;   t2 = -bx; end
			SEC_C3: begin t1 = -z;  t2 = bx;  end
			SEC_C4: begin t1 = -bx; t2 = z;   end
			SEC_C5: begin t1 = bx;  t2 = -y;  end
			SEC_C6: begin t1 = -y;  t2 = -z;  end
			default: ;
		endcase
		d0 = half - t1 - t2;
		d1 = d0 + 2 * t1;
		d2 = d1 + 2 * t2;
		da = half;
		db = half;
		dc = half;
		e.sector = 3'd0;
		case (code)
			SEC_C1: begin db = d0; da = d1; dc = d2; e.sector = 3'd2; shift_flags = 3'b110; end
			SEC_C2: begin da = d0; dc = d1; db = d2; e.sector = 3'd6; shift_flags = 3'b011; end
			SEC_C3: begin da = d0; db = d1; dc = d2; e.sector = 3'd1; shift_flags = 3'b010; end
			SEC_C4: begin dc = d0; db = d1; da = d2; e.sector = 3'd4; shift_flags = 3'b101; end
			SEC_C5: begin db = d0; dc = d1; da = d2; e.sector = 3'd3; shift_flags = 3'b100; end
			SEC_C6: begin dc = d0; da = d1; db = d2; e.sector = 3'd5; shift_flags = 3'b001; end
			default: ;
		endcase
		e.alpha = alpha;
		e.beta = beta;
		e.duty_a = q31_to_q15(da);
		e.duty_b = q31_to_q15(db);
		e.duty_c = q31_to_q15(dc);
		e.off_first = shift_flags[0] ? period_now : '0;
		e.off_second = shift_flags[1] ? period_now : '0;
		e.off_third = shift_flags[2] ? period_now : '0;
		return e;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want,
			input duty_expect_t e);
		$display("%0t: %s mismatch: got %0d, expected %0d (alpha %0d, beta %0d)",
			$realtime, field, got, want, e.alpha, e.beta);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		duty_expect_t e;
		if (!arst_n) begin
			period_now = '0;
			shift_flags = '0;
			duty_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (duty_q.size() == 0) begin
					e = '{default: '0};
					report_mismatch("unexpected result sector", sector_number, 0, e);
				end else begin
					e = duty_q.pop_front();
					if (duty_a !== e.duty_a)
						report_mismatch("duty_a", duty_a, e.duty_a, e);
					if (duty_b !== e.duty_b)
						report_mismatch("duty_b", duty_b, e.duty_b, e);
					if (duty_c !== e.duty_c)
						report_mismatch("duty_c", duty_c, e.duty_c, e);
					if (sector_number !== e.sector)
						report_mismatch("sector_number", sector_number, e.sector, e);
					if (offset_first !== e.off_first)
						report_mismatch("offset_first", offset_first, e.off_first, e);
					if (offset_second !== e.off_second)
						report_mismatch("offset_second", offset_second, e.off_second, e);
					if (offset_third !== e.off_third)
						report_mismatch("offset_third", offset_third, e.off_third, e);
				end
			end
			if (cfg_valid && cfg_ready)
				period_now = phase_period;
			if (in_valid && in_ready)
				duty_q.push_back(predict_duties(alpha_voltage, beta_voltage));
			pending <= duty_q.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives alpha/beta samples and period writes into the space-vector PWM duty
// generator with random idle bursts on both sides, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
	import svpwm_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 313;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [VoltW-1:0] alpha_voltage = '0;
	logic signed [VoltW-1:0] beta_voltage = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b1;
	logic [DutyW-1:0]        duty_a;
	logic [DutyW-1:0]        duty_b;
	logic [DutyW-1:0]        duty_c;
	logic [2:0]              sector_number;
	logic [PerW-1:0]         offset_first;
	logic [PerW-1:0]         offset_second;
	logic [PerW-1:0]         offset_third;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [PerW-1:0]         phase_period = '0;
	logic                    idle_on = 1'b1;
	int                      fail_count;
	int                      pending;

	space_vector_pwm_duty_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.alpha_voltage (alpha_voltage),
		.beta_voltage  (beta_voltage),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duty_a        (duty_a),
		.duty_b        (duty_b),
		.duty_c        (duty_c),
		.sector_number (sector_number),
		.offset_first  (offset_first),
		.offset_second (offset_second),
		.offset_third  (offset_third),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.phase_period  (phase_period)
	);

	svpwm_duty_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.alpha_voltage (alpha_voltage),
		.beta_voltage  (beta_voltage),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duty_a        (duty_a),
		.duty_b        (duty_b),
		.duty_c        (duty_c),
		.sector_number (sector_number),
		.offset_first  (offset_first),
		.offset_second (offset_second),
		.offset_third  (offset_third),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.phase_period  (phase_period),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic send_sample(input logic signed [VoltW-1:0] a, input logic signed [VoltW-1:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		alpha_voltage <= a;
		beta_voltage <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random();
		logic signed [VoltW-1:0] a, b;
		longint                  l;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				a = 16'($urandom());
				b = 16'($urandom());
			end
			5, 6: begin
				a = 16'(int'($urandom_range(0, 46340)) - 23170);
				b = 16'(int'($urandom_range(0, 46340)) - 23170);
			end
			7: begin
				a = 16'(int'($urandom_range(0, 128)) - 64);
				b = 16'(int'($urandom_range(0, 128)) - 64);
			end
			8: begin
				a = $urandom_range(0, 1) ? 16'($urandom()) : '0;
				b = $urandom_range(0, 1) ? 16'($urandom()) : '0;
			end
			default: begin
				// hug a sector boundary
				a = 16'(int'($urandom_range(0, 36000)) - 18000);
				l = (longint'(a) * 56756) >>> 15;
				l = l + int'($urandom_range(0, 2)) - 1;
				b = $urandom_range(0, 1) ? 16'(l) : 16'(-l);
			end
		endcase
		send_sample(a, b);
	endtask

	task automatic write_period(input logic [PerW-1:0] v);
		cfg_valid <= 1'b1;
		phase_period <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_directed();
		logic signed [VoltW-1:0] va[24];
		logic signed [VoltW-1:0] vb[24];
		va = '{0, 32767, 0, -32768, 0, 0, 32767, -32768, 32767, -32768, 1, -1,
			0, 0, 0, 17321, 0, -17321, -17321, 0, 17321, 0, 28378, -1};
		vb = '{0, 0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 0, 0,
			1, -1, 0, 10000, 20000, 10000, -10000, -20000, -10000, 0, 16384, 1};
		foreach (va[i])
			send_sample(va[i], vb[i]);
	endtask

	initial begin : stimulus
		logic [PerW-1:0] periods[PHASES];
		periods = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0000, 16'h0001};
		periods[4] = 16'($urandom());
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			write_period(periods[phase]);
			if (phase == 0)
				run_directed();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0)
					idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
				send_random();
			end
			drain_results();
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
